// ===== src/cpu_6502_instruction_core_macros.svh =====
// assertion helpers
`ifndef CPU_6502_INSTRUCTION_CORE_MACROS_SVH
`define CPU_6502_INSTRUCTION_CORE_MACROS_SVH
`define CHK_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
`define CHK_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== src/c6502_pkg.sv =====
package c6502_pkg;
   localparam logic [1:0] REQ_RESET = 2'd0;
   localparam logic [1:0] REQ_RUN   = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] BUS_DONE  = 2'd0;
   localparam logic [1:0] BUS_READ  = 2'd1;
   localparam logic [1:0] BUS_WRITE = 2'd2;
   localparam logic [7:0] FL_C = 8'h01;
   localparam logic [7:0] FL_Z = 8'h02;
   localparam logic [7:0] FL_I = 8'h04;
   localparam logic [7:0] FL_D = 8'h08;
   localparam logic [7:0] FL_V = 8'h40;
   localparam logic [7:0] FL_N = 8'h80;
   localparam logic [3:0] M_IMP = 4'd0, M_IMM = 4'd1, M_ZP = 4'd2, M_ZPX = 4'd3,
      M_ZPY = 4'd4, M_ABS = 4'd5, M_ABSX = 4'd6, M_ABSY = 4'd7, M_INDX = 4'd8,
      M_INDY = 4'd9;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] start_address;
      logic [7:0]  read_data;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  bus_op;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
      logic        last;
      logic        bad_opcode;
      logic [7:0]  acc_out;
      logic [7:0]  x_out;
      logic [7:0]  y_out;
      logic [7:0]  sp_out;
      logic [7:0]  status_out;
      logic [15:0] pc_out;
   } rsp_word_type;

   function automatic logic is_implied(input logic [7:0] op);
      case (op)
         8'h20, 8'h40, 8'h60, 8'h4C, 8'h6C, 8'h08, 8'h28, 8'h48, 8'h68, 8'h88,
         8'hA8, 8'hC8, 8'hE8, 8'h18, 8'h38, 8'h58, 8'h78, 8'h98, 8'hB8, 8'hD8,
         8'hF8, 8'h8A, 8'h9A, 8'hAA, 8'hBA, 8'hCA, 8'hEA: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic is_official(input logic [7:0] op);
      logic [2:0] aaa, bbb;
      logic [1:0] cc;
      aaa = op[7:5];
      bbb = op[4:2];
      cc  = op[1:0];
      if (is_implied(op) || op[4:0] == 5'h10) return 1'b1;
      if (cc == 2'd1) return op != 8'h89;
      if (cc == 2'd0) begin
         if (aaa == 3'd1) return bbb == 3'd1 || bbb == 3'd3;
         if (aaa == 3'd4) return bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5;
         if (aaa == 3'd5) return bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3 ||
                                 bbb == 3'd5 || bbb == 3'd7;
         if (aaa >= 3'd6) return bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3;
         return 1'b0;
      end
      if (cc == 2'd2) begin
         if (bbb == 3'd0) return aaa == 3'd5;
         if (bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5) return 1'b1;
         if (bbb == 3'd2) return aaa < 3'd4;
         if (bbb == 3'd7) return aaa != 3'd4;
      end
      return 1'b0;
   endfunction

   function automatic logic [3:0] mode_of(input logic [7:0] op);
      logic use_y;
      use_y = (op[1:0] == 2'd2) && (op[7:5] == 3'd4 || op[7:5] == 3'd5);
      if (op == 8'h20) return M_ABS;
      if (op[1:0] == 2'd1) begin
         case (op[4:2])
            3'd0: return M_INDX;
            3'd1: return M_ZP;
            3'd2: return M_IMM;
            3'd3: return M_ABS;
            3'd4: return M_INDY;
            3'd5: return M_ZPX;
            3'd6: return M_ABSY;
            default: return M_ABSX;
         endcase
      end
      case (op[4:2])
         3'd0: return M_IMM;
         3'd1: return M_ZP;
         3'd3: return M_ABS;
         3'd5: return use_y ? M_ZPY : M_ZPX;
         3'd7: return use_y ? M_ABSY : M_ABSX;
         default: return M_IMP;
      endcase
   endfunction

   function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
      return (p & ~(FL_Z | FL_N)) | ((v == 8'h00) ? FL_Z : 8'h00) | (v & FL_N);
   endfunction
endpackage

// ===== src/cpu_6502_instruction_core.sv =====
// Results of an accepted word are registered and appear in the next cycle, one result
// word per cycle while rsp_ready is high. Throughput: one request word per cycle while
// each causes at most one result; the next after k results (up to 3) waits for the last.
// Reset: synchronous, active high; registers take the power-on values (PC 0, SP 0xFD, I set)
// and the result buffer empties.
`include "cpu_6502_instruction_core_macros.svh"
module cpu_6502_instruction_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  c6502_pkg::req_word_type  req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output c6502_pkg::rsp_word_type  rsp_word
);
   import c6502_pkg::*;

   localparam logic [3:0] PH_IDLE = 4'd0, PH_OPCODE = 4'd1, PH_ADDR_LO = 4'd2,
      PH_ADDR_HI = 4'd3, PH_IND_LO = 4'd4, PH_IND_HI = 4'd5, PH_OPERAND = 4'd6,
      PH_RMW = 4'd7, PH_JI_LO = 4'd8, PH_JI_HI = 4'd9, PH_PULL_P = 4'd10,
      PH_PULL_LO = 4'd11, PH_PULL_HI = 4'd12, PH_PULL_A = 4'd13, PH_BRANCH = 4'd14;

   logic [7:0]  a_ff, x_ff, y_ff, sp_ff, p_ff, op_ff, ob_ff;
   logic [7:0]  a_in, x_in, y_in, sp_in, p_in, op_in, ob_in;
   logic [15:0] pc_ff, ea_ff, pc_in, ea_in;
   logic [3:0]  ph_ff, ph_in;
   rsp_word_type buf_ff [3];
   rsp_word_type buf_in [3];
   logic [1:0]  cnt_ff, idx_ff, cnt_in;
   logic        accept, take;

   assign rsp_valid = idx_ff < cnt_ff;
   assign rsp_word  = buf_ff[idx_ff];
   assign take      = rsp_valid && rsp_ready;
   assign req_ready = !rsp_valid || (rsp_ready && idx_ff == cnt_ff - 2'd1);
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic [1:0]  wop  [3];
      logic [15:0] wadr [3];
      logic [7:0]  wdat [3];
      logic        bad, sd, dn, flag;
      logic [3:0]  m;
      logic [7:0]  d, r, mv, v;
      logic [8:0]  sum;
      logic [15:0] ret;
      logic        c;
      logic [1:0]  n;
      for (int i = 0; i < 3; i++) begin
         wop[i] = BUS_DONE;
         wadr[i] = 16'h0;
         wdat[i] = 8'h0;
      end
      a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; p_in = p_ff;
      op_in = op_ff; ob_in = ob_ff; pc_in = pc_ff; ea_in = ea_ff; ph_in = ph_ff;
      bad = 1'b0; sd = 1'b0; dn = 1'b0; flag = 1'b0;
      n = 2'd0; r = 8'h0; mv = 8'h0; v = 8'h0; sum = 9'h0; ret = 16'h0; c = 1'b0;
      d = req_word.read_data;
      m = mode_of(op_ff);
      case (req_word.req_type)
         REQ_RESET: begin
            a_in = 8'h0; x_in = 8'h0; y_in = 8'h0; sp_in = 8'hFD; p_in = FL_I;
            pc_in = req_word.start_address; ph_in = PH_IDLE;
            op_in = 8'h0; ea_in = 16'h0; ob_in = 8'h0;
         end
         REQ_RUN: begin
            if (ph_ff == PH_IDLE) begin
               wop[0] = BUS_READ; wadr[0] = pc_ff; n = 2'd1;
               pc_in = pc_ff + 16'd1; ph_in = PH_OPCODE;
            end
         end
         REQ_READ: begin
            case (ph_ff)
               PH_OPCODE: begin
                  op_in = d;
                  if (!is_official(d)) begin
                     bad = 1'b1; dn = 1'b1;
                  end else if (d[4:0] == 5'h10) begin
                     case (d[7:6])
                        2'd0: flag = p_ff[7];
                        2'd1: flag = p_ff[6];
                        2'd2: flag = p_ff[0];
                        default: flag = p_ff[1];
                     endcase
                     pc_in = pc_ff + 16'd1;
                     if (flag == d[5]) begin
                        wop[0] = BUS_READ; wadr[0] = pc_ff; n = 2'd1; ph_in = PH_BRANCH;
                     end else begin
                        dn = 1'b1;
                     end
                  end else begin
                     case (d)
                        8'h20: begin
                           ret = pc_ff + 16'd1;
                           wop[0] = BUS_WRITE; wadr[0] = {8'h01, sp_ff}; wdat[0] = ret[15:8];
                           wop[1] = BUS_WRITE; wadr[1] = {8'h01, sp_ff - 8'd1};
                           wdat[1] = ret[7:0];
                           sp_in = sp_ff - 8'd2;
                           wop[2] = BUS_READ; wadr[2] = pc_ff; n = 2'd3;
                           pc_in = pc_ff + 16'd1; ph_in = PH_ADDR_LO;
                        end
                        8'h40, 8'h28, 8'h60, 8'h68: begin
                           sp_in = sp_ff + 8'd1;
                           wop[0] = BUS_READ; wadr[0] = {8'h01, sp_ff + 8'd1}; n = 2'd1;
                           ph_in = (d == 8'h60) ? PH_PULL_LO :
                                   (d == 8'h68) ? PH_PULL_A : PH_PULL_P;
                        end
                        8'h08, 8'h48: begin
                           wop[0] = BUS_WRITE; wadr[0] = {8'h01, sp_ff};
                           wdat[0] = (d == 8'h08) ? ((p_ff & 8'hCF) | 8'h30) : a_ff;
                           sp_in = sp_ff - 8'd1; n = 2'd1; dn = 1'b1;
                        end
                        8'h18: begin p_in = p_ff & ~FL_C; dn = 1'b1; end
                        8'h38: begin p_in = p_ff | FL_C; dn = 1'b1; end
                        8'h58: begin p_in = p_ff & ~FL_I; dn = 1'b1; end
                        8'h78: begin p_in = p_ff | FL_I; dn = 1'b1; end
                        8'hB8: begin p_in = p_ff & ~FL_V; dn = 1'b1; end
                        8'hD8: begin p_in = p_ff & ~FL_D; dn = 1'b1; end
                        8'hF8: begin p_in = p_ff | FL_D; dn = 1'b1; end
                        8'h88: begin y_in = y_ff - 8'd1; p_in = set_zn(p_ff, y_in); dn = 1'b1; end
                        8'hCA: begin x_in = x_ff - 8'd1; p_in = set_zn(p_ff, x_in); dn = 1'b1; end
                        8'hC8: begin y_in = y_ff + 8'd1; p_in = set_zn(p_ff, y_in); dn = 1'b1; end
                        8'hE8: begin x_in = x_ff + 8'd1; p_in = set_zn(p_ff, x_in); dn = 1'b1; end
                        8'hA8: begin y_in = a_ff; p_in = set_zn(p_ff, a_ff); dn = 1'b1; end
                        8'h98: begin a_in = y_ff; p_in = set_zn(p_ff, y_ff); dn = 1'b1; end
                        8'h8A: begin a_in = x_ff; p_in = set_zn(p_ff, x_ff); dn = 1'b1; end
                        8'hAA: begin x_in = a_ff; p_in = set_zn(p_ff, a_ff); dn = 1'b1; end
                        8'h9A: begin sp_in = x_ff; dn = 1'b1; end
                        8'hBA: begin x_in = sp_ff; p_in = set_zn(p_ff, sp_ff); dn = 1'b1; end
                        8'hEA: dn = 1'b1;
                        8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
                           case (d[6:5])
                              2'd0: begin r = {a_ff[6:0], 1'b0}; c = a_ff[7]; end
                              2'd1: begin r = {a_ff[6:0], p_ff[0]}; c = a_ff[7]; end
                              2'd2: begin r = {1'b0, a_ff[7:1]}; c = a_ff[0]; end
                              default: begin r = {p_ff[0], a_ff[7:1]}; c = a_ff[0]; end
                           endcase
                           a_in = r; p_in = set_zn({p_ff[7:1], c}, r); dn = 1'b1;
                        end
                        default: begin
                           wop[0] = BUS_READ; wadr[0] = pc_ff; n = 2'd1;
                           pc_in = pc_ff + 16'd1;
                           if (mode_of(d) == M_IMM) begin
                              ea_in = pc_ff; ph_in = PH_OPERAND;
                           end else begin
                              ph_in = PH_ADDR_LO;
                           end
                        end
                     endcase
                  end
               end
               PH_ADDR_LO: begin
                  if (m == M_ZP) begin
                     ea_in = {8'h0, d}; sd = 1'b1;
                  end else if (m == M_ZPX) begin
                     ea_in = {8'h0, d + x_ff}; sd = 1'b1;
                  end else if (m == M_ZPY) begin
                     ea_in = {8'h0, d + y_ff}; sd = 1'b1;
                  end else if (m == M_INDX || m == M_INDY) begin
                     ob_in = (m == M_INDX) ? d + x_ff : d;
                     wop[0] = BUS_READ; wadr[0] = {8'h0, ob_in}; n = 2'd1; ph_in = PH_IND_LO;
                  end else begin
                     ea_in = {8'h0, d};
                     wop[0] = BUS_READ; wadr[0] = pc_ff; n = 2'd1;
                     pc_in = pc_ff + 16'd1; ph_in = PH_ADDR_HI;
                  end
               end
               PH_ADDR_HI: begin
                  ea_in = {d, ea_ff[7:0]};
                  if (m == M_ABSX) ea_in = ea_in + {8'h0, x_ff};
                  if (m == M_ABSY) ea_in = ea_in + {8'h0, y_ff};
                  sd = 1'b1;
               end
               PH_IND_LO: begin
                  ea_in = {8'h0, d};
                  wop[0] = BUS_READ; wadr[0] = {8'h0, ob_ff + 8'd1}; n = 2'd1;
                  ph_in = PH_IND_HI;
               end
               PH_IND_HI: begin
                  ea_in = {d, ea_ff[7:0]};
                  if (m == M_INDY) ea_in = ea_in + {8'h0, y_ff};
                  sd = 1'b1;
               end
               PH_OPERAND: begin
                  dn = 1'b1;
                  if (op_ff[1:0] == 2'd1) begin
                     mv = (op_ff[7:5] == 3'd7) ? ~d : d;
                     case (op_ff[7:5])
                        3'd0: begin a_in = a_ff | d; p_in = set_zn(p_ff, a_in); end
                        3'd1: begin a_in = a_ff & d; p_in = set_zn(p_ff, a_in); end
                        3'd2: begin a_in = a_ff ^ d; p_in = set_zn(p_ff, a_in); end
                        3'd3, 3'd7: begin
                           sum = {1'b0, a_ff} + {1'b0, mv} + {8'h0, p_ff[0]};
                           v = (a_ff ^ sum[7:0]) & (mv ^ sum[7:0]);
                           a_in = sum[7:0];
                           p_in = set_zn({p_ff[7], v[7], p_ff[5:1], sum[8]}, sum[7:0]);
                        end
                        3'd5: begin a_in = d; p_in = set_zn(p_ff, d); end
                        3'd6: p_in = set_zn({p_ff[7:1], a_ff >= d}, a_ff - d);
                        default: ;
                     endcase
                  end else if (op_ff[1:0] == 2'd0) begin
                     case (op_ff[7:5])
                        3'd1: p_in = (p_ff & ~(FL_Z | FL_V | FL_N)) | (d & 8'hC0) |
                                     (((a_ff & d) == 8'h0) ? FL_Z : 8'h0);
                        3'd5: begin y_in = d; p_in = set_zn(p_ff, d); end
                        3'd6: p_in = set_zn({p_ff[7:1], y_ff >= d}, y_ff - d);
                        3'd7: p_in = set_zn({p_ff[7:1], x_ff >= d}, x_ff - d);
                        default: ;
                     endcase
                  end else begin
                     x_in = d; p_in = set_zn(p_ff, d);
                  end
               end
               PH_RMW: begin
                  c = p_ff[0];
                  case (op_ff[7:5])
                     3'd0: begin r = {d[6:0], 1'b0}; c = d[7]; end
                     3'd1: begin r = {d[6:0], p_ff[0]}; c = d[7]; end
                     3'd2: begin r = {1'b0, d[7:1]}; c = d[0]; end
                     3'd3: begin r = {p_ff[0], d[7:1]}; c = d[0]; end
                     3'd6: r = d - 8'd1;
                     default: r = d + 8'd1;
                  endcase
                  p_in = set_zn({p_ff[7:1], c}, r);
                  wop[0] = BUS_WRITE; wadr[0] = ea_ff; wdat[0] = r; n = 2'd1; dn = 1'b1;
               end
               PH_JI_LO: begin
                  ob_in = d;
                  wop[0] = BUS_READ; wadr[0] = {ea_ff[15:8], ea_ff[7:0] + 8'd1}; n = 2'd1;
                  ph_in = PH_JI_HI;
               end
               PH_JI_HI: begin pc_in = {d, ob_ff}; dn = 1'b1; end
               PH_PULL_P: begin
                  p_in = d & 8'hCF;
                  if (op_ff == 8'h40) begin
                     sp_in = sp_ff + 8'd1;
                     wop[0] = BUS_READ; wadr[0] = {8'h01, sp_ff + 8'd1}; n = 2'd1;
                     ph_in = PH_PULL_LO;
                  end else begin
                     dn = 1'b1;
                  end
               end
               PH_PULL_LO: begin
                  ob_in = d; sp_in = sp_ff + 8'd1;
                  wop[0] = BUS_READ; wadr[0] = {8'h01, sp_ff + 8'd1}; n = 2'd1;
                  ph_in = PH_PULL_HI;
               end
               PH_PULL_HI: begin
                  pc_in = {d, ob_ff} + ((op_ff == 8'h60) ? 16'd1 : 16'd0); dn = 1'b1;
               end
               PH_PULL_A: begin a_in = d; p_in = set_zn(p_ff, d); dn = 1'b1; end
               PH_BRANCH: begin pc_in = pc_ff + {{8{d[7]}}, d}; dn = 1'b1; end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (sd) begin
         if (op_ff == 8'h20 || op_ff == 8'h4C) begin
            pc_in = ea_in; dn = 1'b1;
         end else if (op_ff == 8'h6C) begin
            wop[0] = BUS_READ; wadr[0] = ea_in; n = 2'd1; ph_in = PH_JI_LO;
         end else if (op_ff[7:5] == 3'd4) begin
            wop[0] = BUS_WRITE; wadr[0] = ea_in; n = 2'd1; dn = 1'b1;
            wdat[0] = (op_ff[1:0] == 2'd1) ? a_ff : (op_ff[1:0] == 2'd0) ? y_ff : x_ff;
         end else begin
            wop[0] = BUS_READ; wadr[0] = ea_in; n = 2'd1;
            ph_in = (op_ff[1:0] == 2'd2 && op_ff[7:5] != 3'd5) ? PH_RMW : PH_OPERAND;
         end
      end
      if (dn) begin
         wop[n] = BUS_DONE; wadr[n] = 16'h0; wdat[n] = 8'h0;
         n = n + 2'd1; ph_in = PH_IDLE;
      end
      cnt_in = n;
      for (int i = 0; i < 3; i++) begin
         buf_in[i] = '0;
         buf_in[i].bus_op = wop[i];
         buf_in[i].bus_address = wadr[i];
         buf_in[i].write_data = wdat[i];
         buf_in[i].last = (2'(i) == n - 2'd1);
         if (dn && 2'(i) == n - 2'd1) begin
            buf_in[i].bad_opcode = bad;
            buf_in[i].acc_out = a_in;
            buf_in[i].x_out = x_in;
            buf_in[i].y_out = y_in;
            buf_in[i].sp_out = sp_in;
            buf_in[i].status_out = (p_in & 8'hCF) | 8'h30;
            buf_in[i].pc_out = pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= 8'h0; x_ff <= 8'h0; y_ff <= 8'h0; sp_ff <= 8'hFD; p_ff <= FL_I;
         op_ff <= 8'h0; ob_ff <= 8'h0; pc_ff <= 16'h0; ea_ff <= 16'h0; ph_ff <= PH_IDLE;
         cnt_ff <= 2'd0; idx_ff <= 2'd0;
      end else if (accept) begin
         a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; sp_ff <= sp_in; p_ff <= p_in;
         op_ff <= op_in; ob_ff <= ob_in; pc_ff <= pc_in; ea_ff <= ea_in; ph_ff <= ph_in;
         cnt_ff <= cnt_in; idx_ff <= 2'd0;
      end else if (take) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) buf_ff[i] <= buf_in[i];
      end
   end

   `CHK_IMPLY(a_idx_range, clock, reset, 1'b1, idx_ff <= cnt_ff, "read index past fill")
   `CHK_IMPLY(a_last_word, clock, reset, rsp_valid && idx_ff == cnt_ff - 2'd1,
              rsp_word.last, "final word lacks last")
   `CHK_IMPLY(a_no_overrun, clock, reset, req_ready && rsp_valid, rsp_ready,
              "accept while buffer still holds words")
   `CHK_NEXT(a_phase_reset, clock, reset, accept && req_word.req_type == REQ_RESET,
             ph_ff == PH_IDLE && !rsp_valid, "reset word left work behind")
endmodule

// ===== verif/c6502_tb_pkg.sv =====
`timescale 1ns / 100ps
package c6502_tb_pkg;
   localparam logic [7:0] OP_BRK     = 8'h00;
   localparam logic [7:0] OP_PHP     = 8'h08;
   localparam logic [7:0] OP_ASL_A   = 8'h0A;
   localparam logic [7:0] OP_CLC     = 8'h18;
   localparam logic [7:0] OP_JSR     = 8'h20;
   localparam logic [7:0] OP_PLP     = 8'h28;
   localparam logic [7:0] OP_ROL_A   = 8'h2A;
   localparam logic [7:0] OP_SEC     = 8'h38;
   localparam logic [7:0] OP_RTI     = 8'h40;
   localparam logic [7:0] OP_PHA     = 8'h48;
   localparam logic [7:0] OP_LSR_A   = 8'h4A;
   localparam logic [7:0] OP_JMP     = 8'h4C;
   localparam logic [7:0] OP_CLI     = 8'h58;
   localparam logic [7:0] OP_RTS     = 8'h60;
   localparam logic [7:0] OP_ROR_ZP  = 8'h66;
   localparam logic [7:0] OP_PLA     = 8'h68;
   localparam logic [7:0] OP_ADC_IMM = 8'h69;
   localparam logic [7:0] OP_ROR_A   = 8'h6A;
   localparam logic [7:0] OP_JMP_IND = 8'h6C;
   localparam logic [7:0] OP_SEI     = 8'h78;
   localparam logic [7:0] OP_STA_ABX = 8'h9D;
   localparam logic [7:0] OP_DEY     = 8'h88;
   localparam logic [7:0] OP_NOP_IMM = 8'h89;
   localparam logic [7:0] OP_TXA     = 8'h8A;
   localparam logic [7:0] OP_TYA     = 8'h98;
   localparam logic [7:0] OP_TXS     = 8'h9A;
   localparam logic [7:0] OP_LDX_IMM = 8'hA2;
   localparam logic [7:0] OP_LDA_INX = 8'hA1;
   localparam logic [7:0] OP_TAY     = 8'hA8;
   localparam logic [7:0] OP_LDA_IMM = 8'hA9;
   localparam logic [7:0] OP_TAX     = 8'hAA;
   localparam logic [7:0] OP_LDA_INY = 8'hB1;
   localparam logic [7:0] OP_CLV     = 8'hB8;
   localparam logic [7:0] OP_TSX     = 8'hBA;
   localparam logic [7:0] OP_INY     = 8'hC8;
   localparam logic [7:0] OP_DEX     = 8'hCA;
   localparam logic [7:0] OP_BNE     = 8'hD0;
   localparam logic [7:0] OP_CLD     = 8'hD8;
   localparam logic [7:0] OP_INX     = 8'hE8;
   localparam logic [7:0] OP_SBC_IMM = 8'hE9;
   localparam logic [7:0] OP_NOP     = 8'hEA;
   localparam logic [7:0] OP_SED     = 8'hF8;
endpackage

// ===== verif/c6502_checker.sv =====
`timescale 1ns / 100ps
module c6502_checker
   import c6502_pkg::*;
   import c6502_tb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           pending
);
   typedef enum logic [3:0] {
      PH_IDLE, PH_OPCODE, PH_ADDR_LO, PH_ADDR_HI, PH_IND_LO, PH_IND_HI, PH_OPERAND,
      PH_RMW, PH_JI_LO, PH_JI_HI, PH_PULL_P, PH_PULL_LO, PH_PULL_HI, PH_PULL_A, PH_BRANCH
   } seq_phase_type;

   logic [7:0]  acc, xr, yr, sp, pf, cur_op, opb;
   logic [15:0] pc, ea;
   seq_phase_type phase;
   rsp_word_type bus_expect_q[$];

   initial fail_count = 0;
   initial pending = 0;

   function automatic logic op_official(input logic [7:0] op);
      logic [2:0] hi, mid;
      hi  = op[7:5];
      mid = op[4:2];
      case (op)
         OP_JSR, OP_RTI, OP_RTS, OP_JMP, OP_JMP_IND, OP_PHP, OP_PLP, OP_PHA, OP_PLA,
         OP_DEY, OP_TAY, OP_INY, OP_INX, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_TYA,
         OP_CLV, OP_CLD, OP_SED, OP_TXA, OP_TXS, OP_TAX, OP_TSX, OP_DEX, OP_NOP:
            return 1'b1;
         default: ;
      endcase
      if (op[4:0] == 5'h10) return 1'b1;
      case (op[1:0])
         2'd1: return op != OP_NOP_IMM;
         2'd0: begin
            case (hi)
               3'd1: return mid == 3'd1 || mid == 3'd3;
               3'd4: return mid == 3'd1 || mid == 3'd3 || mid == 3'd5;
               3'd5: return mid == 3'd0 || mid == 3'd1 || mid == 3'd3 || mid == 3'd5 ||
                            mid == 3'd7;
               3'd6, 3'd7: return mid == 3'd0 || mid == 3'd1 || mid == 3'd3;
               default: return 1'b0;
            endcase
         end
         2'd2: begin
            case (mid)
               3'd0: return hi == 3'd5;
               3'd1, 3'd3, 3'd5: return 1'b1;
               3'd2: return hi < 3'd4;
               3'd7: return hi != 3'd4;
               default: return 1'b0;
            endcase
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [3:0] mode_decode(input logic [7:0] op);
      logic ysel;
      ysel = op[1:0] == 2'd2 && (op[7:5] == 3'd4 || op[7:5] == 3'd5);
      if (op == OP_JSR) return M_ABS;
      if (op[1:0] == 2'd1) begin
         case (op[4:2])
            3'd0: return M_INDX;
            3'd1: return M_ZP;
            3'd2: return M_IMM;
            3'd3: return M_ABS;
            3'd4: return M_INDY;
            3'd5: return M_ZPX;
            3'd6: return M_ABSY;
            default: return M_ABSX;
         endcase
      end
      case (op[4:2])
         3'd0: return M_IMM;
         3'd1: return M_ZP;
         3'd3: return M_ABS;
         3'd5: return ysel ? M_ZPY : M_ZPX;
         3'd7: return ysel ? M_ABSY : M_ABSX;
         default: return M_IMP;
      endcase
   endfunction

   task automatic power_on(input logic [15:0] start);
      acc = 8'h00; xr = 8'h00; yr = 8'h00; sp = 8'hFD; pf = FL_I; pc = start;
      phase = PH_IDLE; cur_op = 8'h00; ea = 16'h0000; opb = 8'h00;
   endtask

   task automatic emit(input logic [1:0] op, input logic [15:0] a, input logic [7:0] d,
                       input logic bad, input logic regs);
      rsp_word_type w;
      w = '0;
      w.bus_op = op;
      w.bus_address = a;
      w.write_data = d;
      w.bad_opcode = bad;
      if (regs) begin
         w.acc_out = acc; w.x_out = xr; w.y_out = yr; w.sp_out = sp;
         w.status_out = (pf & 8'hCF) | 8'h30;
         w.pc_out = pc;
      end
      bus_expect_q.push_back(w);
   endtask

   task automatic bus_read(input logic [15:0] a, input seq_phase_type ph);
      phase = ph;
      emit(BUS_READ, a, 8'h00, 1'b0, 1'b0);
   endtask

   task automatic finish_op(input logic bad);
      phase = PH_IDLE;
      emit(BUS_DONE, 16'h0000, 8'h00, bad, 1'b1);
   endtask

   task automatic push_byte(input logic [7:0] v);
      emit(BUS_WRITE, {8'h01, sp}, v, 1'b0, 1'b0);
      sp = sp - 8'd1;
   endtask

   task automatic pull_byte(input seq_phase_type ph);
      sp = sp + 8'd1;
      bus_read({8'h01, sp}, ph);
   endtask

   task automatic fetch_pc(input seq_phase_type ph);
      logic [15:0] a;
      a = pc;
      pc = pc + 16'd1;
      bus_read(a, ph);
   endtask

   task automatic upd_zn(input logic [7:0] v);
      pf = (pf & ~(FL_Z | FL_N)) | ((v == 8'h00) ? FL_Z : 8'h00) | (v & FL_N);
   endtask

   task automatic add_carry(input logic [7:0] m);
      logic [8:0] sum;
      logic [7:0] ov;
      sum = {1'b0, acc} + {1'b0, m} + {8'h00, pf[0]};
      ov = (acc ^ sum[7:0]) & (m ^ sum[7:0]) & 8'h80;
      pf = (pf & ~(FL_C | FL_V)) | (sum[8] ? FL_C : 8'h00) | ((ov != 0) ? FL_V : 8'h00);
      acc = sum[7:0];
      upd_zn(acc);
   endtask

   task automatic compare_reg(input logic [7:0] r, input logic [7:0] m);
      pf = (pf & ~FL_C) | ((r >= m) ? FL_C : 8'h00);
      upd_zn(r - m);
   endtask

   task automatic shift_op(input logic [2:0] which, input logic [7:0] v,
                           output logic [7:0] r);
      logic c;
      c = pf[0];
      case (which)
         3'd0, 3'd1: begin
            r = {v[6:0], (which == 3'd1) ? c : 1'b0};
            c = v[7];
         end
         3'd2, 3'd3: begin
            r = {(which == 3'd3) ? c : 1'b0, v[7:1]};
            c = v[0];
         end
         3'd6: r = v - 8'd1;
         default: r = v + 8'd1;
      endcase
      pf = (pf & ~FL_C) | {7'd0, c};
      upd_zn(r);
   endtask

   task automatic start_data();
      if (cur_op == OP_JSR || cur_op == OP_JMP) begin
         pc = ea;
         finish_op(1'b0);
      end else if (cur_op == OP_JMP_IND) begin
         bus_read(ea, PH_JI_LO);
      end else if (cur_op[7:5] == 3'd4) begin
         emit(BUS_WRITE, ea, cur_op[1:0] == 2'd1 ? acc : (cur_op[1:0] == 2'd0 ? yr : xr),
              1'b0, 1'b0);
         finish_op(1'b0);
      end else if (cur_op[1:0] == 2'd2 && cur_op[7:5] != 3'd5) begin
         bus_read(ea, PH_RMW);
      end else begin
         bus_read(ea, PH_OPERAND);
      end
   endtask

   task automatic decode_opcode(input logic [7:0] op);
      logic fin, flag;
      logic [15:0] ret;
      logic [7:0] r;
      fin = 1'b1;
      cur_op = op;
      if (!op_official(op)) begin
         finish_op(1'b1);
      end else if (op[4:0] == 5'h10) begin
         case (op[7:6])
            2'd0: flag = pf[7];
            2'd1: flag = pf[6];
            2'd2: flag = pf[0];
            default: flag = pf[1];
         endcase
         if (flag == op[5]) begin
            fetch_pc(PH_BRANCH);
         end else begin
            pc = pc + 16'd1;
            finish_op(1'b0);
         end
      end else begin
         case (op)
            OP_JSR: begin
               ret = pc + 16'd1;
               push_byte(ret[15:8]);
               push_byte(ret[7:0]);
               fetch_pc(PH_ADDR_LO);
               fin = 1'b0;
            end
            OP_RTI, OP_PLP: begin pull_byte(PH_PULL_P); fin = 1'b0; end
            OP_RTS: begin pull_byte(PH_PULL_LO); fin = 1'b0; end
            OP_PLA: begin pull_byte(PH_PULL_A); fin = 1'b0; end
            OP_PHP: push_byte((pf & 8'hCF) | 8'h30);
            OP_PHA: push_byte(acc);
            OP_CLC: pf = pf & ~FL_C;
            OP_SEC: pf = pf | FL_C;
            OP_CLI: pf = pf & ~FL_I;
            OP_SEI: pf = pf | FL_I;
            OP_CLV: pf = pf & ~FL_V;
            OP_CLD: pf = pf & ~FL_D;
            OP_SED: pf = pf | FL_D;
            OP_DEY: begin yr = yr - 8'd1; upd_zn(yr); end
            OP_DEX: begin xr = xr - 8'd1; upd_zn(xr); end
            OP_INY: begin yr = yr + 8'd1; upd_zn(yr); end
            OP_INX: begin xr = xr + 8'd1; upd_zn(xr); end
            OP_TAY: begin yr = acc; upd_zn(yr); end
            OP_TYA: begin acc = yr; upd_zn(acc); end
            OP_TXA: begin acc = xr; upd_zn(acc); end
            OP_TAX: begin xr = acc; upd_zn(xr); end
            OP_TXS: sp = xr;
            OP_TSX: begin xr = sp; upd_zn(xr); end
            OP_NOP: ;
            OP_ASL_A, OP_ROL_A, OP_LSR_A, OP_ROR_A: begin
               shift_op(op[7:5], acc, r);
               acc = r;
            end
            default: begin
               fin = 1'b0;
               if (mode_decode(op) == M_IMM) begin
                  ea = pc;
                  pc = pc + 16'd1;
                  bus_read(ea, PH_OPERAND);
               end else begin
                  fetch_pc(PH_ADDR_LO);
               end
            end
         endcase
         if (fin) finish_op(1'b0);
      end
   endtask

   task automatic apply_operand(input logic [7:0] d);
      if (cur_op[1:0] == 2'd1) begin
         case (cur_op[7:5])
            3'd0: begin acc = acc | d; upd_zn(acc); end
            3'd1: begin acc = acc & d; upd_zn(acc); end
            3'd2: begin acc = acc ^ d; upd_zn(acc); end
            3'd3: add_carry(d);
            3'd5: begin acc = d; upd_zn(acc); end
            3'd6: compare_reg(acc, d);
            3'd7: add_carry(~d);
            default: ;
         endcase
      end else if (cur_op[1:0] == 2'd0) begin
         case (cur_op[7:5])
            3'd1: pf = (pf & ~(FL_Z | FL_V | FL_N)) | (d & 8'hC0) |
                       (((acc & d) == 8'h00) ? FL_Z : 8'h00);
            3'd5: begin yr = d; upd_zn(yr); end
            3'd6: compare_reg(yr, d);
            3'd7: compare_reg(xr, d);
            default: ;
         endcase
      end else begin
         xr = d;
         upd_zn(xr);
      end
   endtask

   task automatic core_step(input req_word_type w);
      logic [3:0] m;
      logic [7:0] d, t;
      int base;
      rsp_word_type tail;
      m = mode_decode(cur_op);
      d = w.read_data;
      base = bus_expect_q.size();
      if (w.req_type == REQ_RESET) begin
         power_on(w.start_address);
      end else if (w.req_type == REQ_RUN) begin
         if (phase == PH_IDLE) fetch_pc(PH_OPCODE);
      end else if (w.req_type == REQ_READ) begin
         case (phase)
            PH_OPCODE: decode_opcode(d);
            PH_ADDR_LO: begin
               if (m == M_ZP) begin
                  ea = {8'h00, d}; start_data();
               end else if (m == M_ZPX) begin
                  t = d + xr; ea = {8'h00, t}; start_data();
               end else if (m == M_ZPY) begin
                  t = d + yr; ea = {8'h00, t}; start_data();
               end else if (m == M_INDX || m == M_INDY) begin
                  opb = (m == M_INDX) ? d + xr : d;
                  bus_read({8'h00, opb}, PH_IND_LO);
               end else begin
                  ea = {8'h00, d};
                  fetch_pc(PH_ADDR_HI);
               end
            end
            PH_ADDR_HI: begin
               ea = {d, ea[7:0]};
               if (m == M_ABSX) ea = ea + {8'h00, xr};
               if (m == M_ABSY) ea = ea + {8'h00, yr};
               start_data();
            end
            PH_IND_LO: begin
               ea = {8'h00, d};
               t = opb + 8'd1;
               bus_read({8'h00, t}, PH_IND_HI);
            end
            PH_IND_HI: begin
               ea = {d, ea[7:0]};
               if (m == M_INDY) ea = ea + {8'h00, yr};
               start_data();
            end
            PH_OPERAND: begin apply_operand(d); finish_op(1'b0); end
            PH_RMW: begin
               shift_op(cur_op[7:5], d, t);
               emit(BUS_WRITE, ea, t, 1'b0, 1'b0);
               finish_op(1'b0);
            end
            PH_JI_LO: begin
               opb = d;
               t = ea[7:0] + 8'd1;
               bus_read({ea[15:8], t}, PH_JI_HI);
            end
            PH_JI_HI: begin pc = {d, opb}; finish_op(1'b0); end
            PH_PULL_P: begin
               pf = d & 8'hCF;
               if (cur_op == OP_RTI) pull_byte(PH_PULL_LO);
               else finish_op(1'b0);
            end
            PH_PULL_LO: begin opb = d; pull_byte(PH_PULL_HI); end
            PH_PULL_HI: begin
               pc = {d, opb};
               if (cur_op == OP_RTS) pc = pc + 16'd1;
               finish_op(1'b0);
            end
            PH_PULL_A: begin acc = d; upd_zn(acc); finish_op(1'b0); end
            PH_BRANCH: begin pc = pc + {{8{d[7]}}, d}; finish_op(1'b0); end
            default: ;
         endcase
      end
      if (bus_expect_q.size() > base) begin
         tail = bus_expect_q.pop_back();
         tail.last = 1'b1;
         bus_expect_q.push_back(tail);
      end
   endtask

   task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
      fail_count++;
   endtask

   task automatic check_word(input rsp_word_type got);
      rsp_word_type exp;
      if (bus_expect_q.size() == 0) begin
         report("unexpected word, bus_address", got.bus_address, 16'h0000);
      end else begin
         exp = bus_expect_q.pop_front();
         if (got.bus_op != exp.bus_op) report("bus_op", got.bus_op, exp.bus_op);
         if (got.bus_address != exp.bus_address)
            report("bus_address", got.bus_address, exp.bus_address);
         if (got.write_data != exp.write_data)
            report("write_data", got.write_data, exp.write_data);
         if (got.last != exp.last) report("last", got.last, exp.last);
         if (got.bad_opcode != exp.bad_opcode)
            report("bad_opcode", got.bad_opcode, exp.bad_opcode);
         if (got.acc_out != exp.acc_out) report("acc_out", got.acc_out, exp.acc_out);
         if (got.x_out != exp.x_out) report("x_out", got.x_out, exp.x_out);
         if (got.y_out != exp.y_out) report("y_out", got.y_out, exp.y_out);
         if (got.sp_out != exp.sp_out) report("sp_out", got.sp_out, exp.sp_out);
         if (got.status_out != exp.status_out)
            report("status_out", got.status_out, exp.status_out);
         if (got.pc_out != exp.pc_out) report("pc_out", got.pc_out, exp.pc_out);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         power_on(16'h0000);
         bus_expect_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_word(rsp_word);
         if (req_valid && req_ready) core_step(req_word);
      end
      pending = bus_expect_q.size();
   end
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
module tb;
   import c6502_pkg::*;
   import c6502_tb_pkg::*;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;
   int           fail_count;
   int           pending;
   logic         req_fire = 1'b0;
   logic         rsp_fire = 1'b0;
   int           reads_seen = 0;
   int           done_seen = 0;
   int           words_sent = 0;
   bit           calm = 1'b0;

   cpu_6502_instruction_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   c6502_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      rsp_fire <= rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_word.bus_op == BUS_READ) reads_seen <= reads_seen + 1;
         if (rsp_word.bus_op == BUS_DONE) done_seen <= done_seen + 1;
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = calm ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_fire);
      end
   end

   task automatic send(input logic [1:0] kind, input logic [15:0] start,
                       input logic [7:0] data);
      int gap;
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{req_type: kind, start_address: start, read_data: data};
      do @(negedge clock); while (!req_fire);
      words_sent++;
   endtask

   // idle step with no word offered
   task automatic idle();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      while (pending != 0) idle();
   endtask

   // one instruction: run word, then answer every read request until completion
   task automatic run_instr(input logic [7:0] op, input logic [7:0] d0, input logic [7:0] d1,
                            input logic [7:0] d2, input bit twice);
      int rb, db, k;
      logic [7:0] b;
      rb = reads_seen;
      db = done_seen;
      k = 0;
      send(REQ_RUN, $urandom, $urandom);
      if (twice) send(REQ_RUN, $urandom, $urandom);
      while (done_seen == db) begin
         while (reads_seen - rb <= k && done_seen == db) idle();
         if (done_seen == db) begin
            case (k)
               0: b = op;
               1: b = d0;
               2: b = d1;
               3: b = d2;
               default: b = $urandom;
            endcase
            send(REQ_READ, $urandom, b);
            k++;
         end
      end
   endtask

   task automatic rand_instr();
      run_instr($urandom, $urandom, $urandom, $urandom, 1'b0);
   endtask

   // reset word in the middle of an instruction
   task automatic abort_instr();
      int rb;
      rb = reads_seen;
      send(REQ_RUN, $urandom, $urandom);
      while (reads_seen == rb) idle();
      send(REQ_READ, $urandom, OP_JMP_IND);
      send(REQ_RESET, $urandom, $urandom);
      drain();
      repeat (3) idle();
   endtask

   initial begin
      int r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(REQ_RESET, 16'hFFFF, 8'hFF);
      run_instr(OP_LDA_IMM, 8'h80, 8'h00, 8'h00, 1'b0);
      run_instr(OP_ADC_IMM, 8'h80, 8'h00, 8'h00, 1'b0);
      run_instr(OP_SBC_IMM, 8'h01, 8'h00, 8'h00, 1'b0);
      run_instr(OP_SEC, 8'h00, 8'h00, 8'h00, 1'b1);
      run_instr(OP_ROR_ZP, 8'hFF, 8'h01, 8'h00, 1'b0);
      run_instr(OP_LDX_IMM, 8'hFF, 8'h00, 8'h00, 1'b0);
      run_instr(OP_LDA_INX, 8'hFF, 8'h34, 8'h12, 1'b0);
      run_instr(OP_LDA_INY, 8'hFF, 8'hF0, 8'hFF, 1'b0);
      run_instr(OP_STA_ABX, 8'hFF, 8'hFF, 8'h00, 1'b0);
      run_instr(OP_JMP_IND, 8'hFF, 8'h12, 8'h80, 1'b0);
      run_instr(OP_JSR, 8'h00, 8'hC0, 8'h00, 1'b0);
      run_instr(OP_RTS, 8'hFF, 8'hFF, 8'h00, 1'b0);
      run_instr(OP_PHP, 8'h00, 8'h00, 8'h00, 1'b0);
      run_instr(OP_RTI, 8'hFF, 8'h00, 8'h80, 1'b0);
      run_instr(OP_BNE, 8'h80, 8'h00, 8'h00, 1'b0);
      run_instr(OP_BRK, 8'h00, 8'h00, 8'h00, 1'b0);
      run_instr(OP_NOP_IMM, 8'h00, 8'h00, 8'h00, 1'b0);
      send(REQ_READ, 16'h0000, 8'h00);
      send(2'd3, 16'hFFFF, 8'hFF);
      abort_instr();
      drain();

      while (words_sent < 170) begin
         r = $urandom_range(0, 99);
         if (r < 84) begin
            rand_instr();
         end else if (r < 88) begin
            send(REQ_READ, $urandom, $urandom);
         end else if (r < 91) begin
            send(2'd3, $urandom, $urandom);
         end else if (r < 95) begin
            send(REQ_RESET, $urandom, $urandom);
         end else if (r < 97) begin
            abort_instr();
         end else begin
            drain();
            rand_instr();
         end
      end
      req_valid <= 1'b0;

      drain();
      repeat (20) @(negedge clock);
      $display("%0d request words sent, %0d reads requested, %0d instructions completed",
               words_sent, reads_seen, done_seen);
      $display("covered load/store, ALU, shifts, stack, jumps, branches and bad opcodes");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
